// File: design/spd_pkg.sv
// Shared types and constants for the shortest path block.
package spd_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam int          DIST_W   = 26;
    localparam logic [25:0] DIST_MAX = 26'h3FF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN_RD,
        ST_SCAN,
        ST_PICK,
        ST_EDGE_RD,
        ST_EDGE,
        ST_RELAX_RD,
        ST_RELAX,
        ST_DONE
    } spd_state_t;

endpackage

// File: design/shortest_path_dijkstra.sv
// Top level of the shortest path block: edge table, node store and search sequencer.
//
// Usage: one input channel (s_valid/s_ready) carries operation, node_a, node_b
// and weight. A clear or an add is accepted and gives no beat on the
// result channel. A query gives one result beat (m_distance, m_reachable,
// m_edge_overflow) on m_valid/m_ready.
// node_count is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce this. A query
// first sweeps the node store, then per settled node scans all nodes for the
// minimum and walks the edge table. Node store and edge table are each read
// through a single read port. s_ready stays low during a query and until its
// result beat is taken; a stalled receiver holds the result. Reset clears the
// edge count and the overflow flag and sets node_count to MAX_NODES; memories
// are not cleared.
module shortest_path_dijkstra #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [9:0]  s_node_a,
    input  logic [9:0]  s_node_b,
    input  logic [15:0] s_weight,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [25:0] m_distance,
    output logic        m_reachable,
    output logic        m_edge_overflow
);
    import spd_pkg::*;

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NC = NW + 1;
    localparam int EC = EW + 1;

    // node entry: reached, settled, distance
    localparam int NEW_W = DIST_W + 2;

    logic [35:0]      edge_mem [MAX_EDGES];
    logic [NEW_W-1:0] node_mem [MAX_NODES];

    spd_state_t state_reg, state_next;
    logic [EC-1:0] edge_total_reg;
    logic          dropped_reg;
    logic [10:0]   node_count_reg;

    logic [NW-1:0] src_reg, dst_reg, src_next, dst_next;
    logic [NC-1:0] idx_reg, idx_next;
    logic [EC-1:0] eidx_reg, eidx_next;
    logic          found_reg, found_next;
    logic [NW-1:0] best_reg, best_next;
    logic [25:0]   bdist_reg, bdist_next;
    logic [NW-1:0] to_reg, to_next;
    logic [25:0]   cand_reg, cand_next;
    logic [25:0]   res_dist_reg, res_dist_next;
    logic          res_ok_reg, res_ok_next;

    logic [35:0]      edge_rd_reg;
    logic [NEW_W-1:0] node_rd_reg;
    logic          n_we;
    logic [NW-1:0] n_waddr, n_raddr;
    logic [NEW_W-1:0] n_wdata;
    logic [EW-1:0] e_raddr;

    logic [NC-1:0] n_act;
    logic          in_fire, add_ok;
    logic [NC-1:0] src_ext, dst_ext;
    logic [9:0]    ea, eb;
    logic [15:0]   ew;
    logic [NC-1:0] ea_ext, eb_ext, best_ext, oth_ext;
    logic [26:0]   sum;

    always_comb begin
        if (node_count_reg == 11'd0) begin
            n_act = NC'(1);
        end else if (32'(node_count_reg) > 32'(MAX_NODES)) begin
            n_act = NC'(MAX_NODES);
        end else begin
            n_act = NC'(node_count_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign add_ok  = 32'(edge_total_reg) < 32'(MAX_EDGES);

    assign ea = edge_rd_reg[9:0];
    assign eb = edge_rd_reg[19:10];
    assign ew = edge_rd_reg[35:20];
    assign ea_ext   = NC'(ea);
    assign eb_ext   = NC'(eb);
    assign best_ext = NC'(best_reg);
    assign oth_ext  = (ea_ext == best_ext) ? eb_ext : ea_ext;
    assign src_ext  = NC'(s_node_a);
    assign dst_ext  = NC'(s_node_b);
    assign sum = {1'b0, bdist_reg} + 27'(ew);

    always_ff @(posedge aclk) begin
        if (in_fire && s_operation == OP_ADD && add_ok) begin
            edge_mem[edge_total_reg[EW-1:0]] <= {s_weight, s_node_b, s_node_a};
        end
        edge_rd_reg <= edge_mem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (n_we) begin
            node_mem[n_waddr] <= n_wdata;
        end
        node_rd_reg <= node_mem[n_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edge_total_reg <= '0;
            dropped_reg    <= 1'b0;
            node_count_reg <= 11'(MAX_NODES);
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (in_fire && s_operation == OP_CLEAR) begin
                edge_total_reg <= '0;
                dropped_reg    <= 1'b0;
            end else if (in_fire && s_operation == OP_ADD) begin
                if (add_ok) begin
                    edge_total_reg <= edge_total_reg + EC'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        idx_reg      <= idx_next;
        eidx_reg     <= eidx_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        bdist_reg    <= bdist_next;
        to_reg       <= to_next;
        cand_reg     <= cand_next;
        res_dist_reg <= res_dist_next;
        res_ok_reg   <= res_ok_next;
    end

    always_comb begin
        state_next    = state_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        idx_next      = idx_reg;
        eidx_next     = eidx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bdist_next    = bdist_reg;
        to_next       = to_reg;
        cand_next     = cand_reg;
        res_dist_next = res_dist_reg;
        res_ok_next   = res_ok_reg;
        n_we    = 1'b0;
        n_waddr = idx_reg[NW-1:0];
        n_wdata = '0;
        n_raddr = idx_reg[NW-1:0];
        e_raddr = eidx_reg[EW-1:0];
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_operation == OP_QUERY) begin
                    src_next      = s_node_a[NW-1:0];
                    dst_next      = s_node_b[NW-1:0];
                    idx_next      = '0;
                    res_dist_next = '0;
                    res_ok_next   = 1'b0;
                    if (src_ext >= n_act || dst_ext >= n_act) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                n_we    = 1'b1;
                n_wdata = (idx_reg[NW-1:0] == src_reg) ? {1'b1, 1'b0, 26'd0} : '0;
                if (idx_reg + NC'(1) == n_act) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN_RD;
                end else begin
                    idx_next = idx_reg + NC'(1);
                end
            end
            ST_SCAN_RD: begin
                // read of idx issued; next index read in ST_SCAN
                idx_next   = idx_reg + NC'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // node_rd_reg holds entry idx_reg-1
                n_raddr = idx_reg[NW-1:0];
                if (node_rd_reg[NEW_W-1] && !node_rd_reg[NEW_W-2] &&
                    (!found_reg || node_rd_reg[25:0] < bdist_reg)) begin
                    found_next = 1'b1;
                    best_next  = NW'(idx_reg - NC'(1));
                    bdist_next = node_rd_reg[25:0];
                end
                if (idx_reg == n_act) begin
                    state_next = ST_PICK;
                end else begin
                    idx_next = idx_reg + NC'(1);
                end
            end
            ST_PICK: begin
                if (!found_reg) begin
                    state_next = ST_DONE;
                end else begin
                    n_we    = 1'b1;
                    n_waddr = best_reg;
                    n_wdata = {1'b1, 1'b1, bdist_reg};
                    if (best_reg == dst_reg) begin
                        res_dist_next = bdist_reg;
                        res_ok_next   = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        eidx_next = '0;
                        if (edge_total_reg == '0) begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN_RD;
                        end else begin
                            state_next = ST_EDGE_RD;
                        end
                    end
                end
            end
            ST_EDGE_RD: begin
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                eidx_next = eidx_reg + EC'(1);
                if ((ea_ext == best_ext || eb_ext == best_ext) &&
                    ea_ext < n_act && eb_ext < n_act) begin
                    to_next    = NW'(oth_ext);
                    cand_next  = sum[26] ? DIST_MAX : sum[25:0];
                    n_raddr    = NW'(oth_ext);
                    state_next = ST_RELAX_RD;
                end else if (eidx_reg + EC'(1) == edge_total_reg) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN_RD;
                end else begin
                    state_next = ST_EDGE_RD;
                end
            end
            ST_RELAX_RD: begin
                n_raddr    = to_reg;
                state_next = ST_RELAX;
            end
            ST_RELAX: begin
                if (!node_rd_reg[NEW_W-2] &&
                    (!node_rd_reg[NEW_W-1] || cand_reg < node_rd_reg[25:0])) begin
                    n_we    = 1'b1;
                    n_waddr = to_reg;
                    n_wdata = {1'b1, 1'b0, cand_reg};
                end
                if (eidx_reg == edge_total_reg) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN_RD;
                end else begin
                    state_next = ST_EDGE_RD;
                end
            end
            ST_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_distance      = res_dist_reg;
    assign m_reachable     = res_ok_reg;
    assign m_edge_overflow = dropped_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(edge_total_reg) <= 32'(MAX_EDGES))
        else $error("edge count overflow");
    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reachable) |-> (m_distance == '0))
        else $error("unreachable with nonzero distance");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_distance)))
        else $error("result dropped while stalled");
endmodule
